[rtl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pairwise circle collision block.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int MAX_BODIES = 64;
    localparam int COORD_BITS = 24;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int IDX_W = $clog2(MAX_BODIES);
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int OUT_IDX_W = 6;
    localparam int SQ_W = 2 * COORD_BITS;

    // Stored body: positions in offset binary, so unsigned compare orders them
    typedef struct packed {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [RADIUS_BITS-1:0] r;
    } t_body;

    // Result of one pair test leaving the compare pipeline
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_cmp;

    // Flip the sign bit: two's complement to offset binary
    function automatic logic [COORD_BITS-1:0] to_offset(input logic [COORD_BITS-1:0] v);
        return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
    endfunction

endpackage

[rtl/pcc_ifs.sv]
// ----------------------------------------------------------------------------
// pcc_ifs
// Valid/ready channels of the collision block: body input and pair output.
// ----------------------------------------------------------------------------
interface pcc_body_if
    import pcc_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic        [RADIUS_BITS-1:0] radius;
    logic                          frame_end;

    modport source (output valid, pos_x, pos_y, radius, frame_end, input ready);
    modport sink   (input valid, pos_x, pos_y, radius, frame_end, output ready);
endinterface

interface pcc_pair_if
    import pcc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic                 last_of_run;

    modport source (output valid, first_index, second_index, last_of_run, input ready);
    modport sink   (input valid, first_index, second_index, last_of_run, output ready);
endinterface

[rtl/pcc_store.sv]
// ----------------------------------------------------------------------------
// pcc_store
// Body memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcc_store
    import pcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_body            i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_body            o_rd_data
);

    t_body r_mem [MAX_BODIES];
    t_body r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data while the scan is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pcc_test.sv]
// ----------------------------------------------------------------------------
// pcc_test
// Three-stage pair test: differences, squares, sum and compare.
// ----------------------------------------------------------------------------
module pcc_test
    import pcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_idx,
    input  t_body            i_stored,
    input  t_body            i_new,
    output t_cmp             o_cmp,
    output logic             o_busy
);

    logic                  r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]      r_idx2, r_idx3, r_idx4;
    logic [COORD_BITS-1:0] r_dx, r_dy, r_rs;
    logic [SQ_W-1:0]       r_dx2, r_dy2, r_rs2;
    logic                  r_hit4;

    logic [COORD_BITS-1:0] n_dx, n_dy, n_rs;
    logic [SQ_W:0]         n_dist;

    always_comb begin
        n_dx = (i_stored.x > i_new.x) ? i_stored.x - i_new.x : i_new.x - i_stored.x;
        n_dy = (i_stored.y > i_new.y) ? i_stored.y - i_new.y : i_new.y - i_stored.y;
        n_rs = {1'b0, i_stored.r} + {1'b0, i_new.r};
        n_dist = {1'b0, r_dx2} + {1'b0, r_dy2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx2 <= i_idx;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_rs   <= n_rs;
            r_idx3 <= r_idx2;
            r_dx2  <= r_dx * r_dx;
            r_dy2  <= r_dy * r_dy;
            r_rs2  <= r_rs * r_rs;
            r_idx4 <= r_idx3;
            r_hit4 <= (n_dist <= {1'b0, r_rs2});
        end
    end

    assign o_cmp.valid = r_v4;
    assign o_cmp.hit   = r_hit4;
    assign o_cmp.idx   = r_idx4;
    assign o_busy      = r_v2 | r_v3 | r_v4;

endmodule

[rtl/pairwise_circle_collision.sv]
// ----------------------------------------------------------------------------
// pairwise_circle_collision
// All-pairs circle collision detection over the bodies of one frame.
// ----------------------------------------------------------------------------
// Each body transfer (signed Q16.8 position, unsigned radius) is stored and
// compared with every body stored earlier in the frame; one pair transfer
// (earlier index, new index) leaves for each pair with dx^2+dy^2 <= (r1+r2)^2,
// in ascending order of the earlier index, and last_of_run marks the final
// pair caused by a body. A body with frame_end set closes the frame and empties
// the store. Once the store holds MAX_BODIES bodies, further bodies of the frame
// are dropped without results. A body arriving as body n of its frame is
// compared with the n bodies before it; the next body can transfer only once the
// block is idle again, which needs no scan when n is zero or the store is full.
// The scan reads one stored body per cycle from the single read port of the body
// memory, unless a stall on the pair output holds it; behind it lie the read
// register and the three compare stages, and the drain state then releases the held pair and returns to idle.
// No clearing pass is needed after reset; the body count alone bounds the scan.
// ----------------------------------------------------------------------------
module pairwise_circle_collision
    import pcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcc_body_if.sink   i_body,
    pcc_pair_if.source o_pair
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_j, n_j;
    logic [IDX_W-1:0]     r_last_j, n_last_j;
    logic [IDX_W-1:0]     r_new_idx, n_new_idx;
    t_body                r_new, n_new;
    logic                 r_v1, n_v1;
    logic [IDX_W-1:0]     r_idx1, n_idx1;
    logic                 r_pend_v, n_pend_v;
    logic [IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0] r_out_first, n_out_first;
    logic [OUT_IDX_W-1:0] r_out_second, n_out_second;
    logic                 r_out_last, n_out_last;

    logic       accept;
    logic       advance;
    logic       has_room;
    logic       wr_en;
    logic       rd_en;
    t_body      wr_data;
    t_body      rd_data;
    t_cmp       cmp;
    logic       test_busy;

    assign i_body.ready = (r_state == S_IDLE);
    assign accept       = i_body.valid && i_body.ready;
    assign has_room     = (r_count < CNT_W'(MAX_BODIES));

    // Freeze the scan when a hit needs the output register and it is still full
    assign advance = !(cmp.valid && cmp.hit && r_pend_v && r_out_valid && !o_pair.ready);

    assign wr_en        = accept && has_room;
    assign wr_data.x    = to_offset(i_body.pos_x);
    assign wr_data.y    = to_offset(i_body.pos_y);
    assign wr_data.r    = i_body.radius;
    assign rd_en        = (r_state == S_SCAN) && advance;

    pcc_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(r_count)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_j),
        .o_rd_data (rd_data)
    );

    pcc_test u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_valid  (r_v1),
        .i_idx    (r_idx1),
        .i_stored (rd_data),
        .i_new    (r_new),
        .o_cmp    (cmp),
        .o_busy   (test_busy)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_j          = r_j;
        n_last_j     = r_last_j;
        n_new_idx    = r_new_idx;
        n_new        = r_new;
        n_v1         = r_v1;
        n_idx1       = r_idx1;
        n_pend_v     = r_pend_v;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !o_pair.ready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_last   = r_out_last;

        // Advance the read stage alongside the compare pipeline
        if (advance) begin
            n_v1   = (r_state == S_SCAN);
            n_idx1 = r_j;
        end

        // A new hit pushes the held one out; the held one is not the last
        if (advance && cmp.valid && cmp.hit) begin
            if (r_pend_v) begin
                n_out_valid  = 1'b1;
                n_out_first  = OUT_IDX_W'(r_pend_idx);
                n_out_second = OUT_IDX_W'(r_new_idx);
                n_out_last   = 1'b0;
            end
            n_pend_v   = 1'b1;
            n_pend_idx = cmp.idx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (has_room) begin
                        n_new     = wr_data;
                        n_new_idx = IDX_W'(r_count);
                        n_last_j  = IDX_W'(r_count - CNT_W'(1));
                        n_j       = '0;
                        n_count   = i_body.frame_end ? '0 : r_count + CNT_W'(1);
                        if (r_count != '0) begin
                            n_state = S_SCAN;
                        end
                    end else if (i_body.frame_end) begin
                        n_count = '0;
                    end
                end
            end
            S_SCAN: begin
                if (advance) begin
                    n_j = r_j + IDX_W'(1);
                    if (r_j == r_last_j) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // Once the pipeline is empty, release the held hit as the last
                if (!r_v1 && !test_busy) begin
                    if (!r_pend_v) begin
                        n_state = S_IDLE;
                    end else if (!r_out_valid || o_pair.ready) begin
                        n_out_valid  = 1'b1;
                        n_out_first  = OUT_IDX_W'(r_pend_idx);
                        n_out_second = OUT_IDX_W'(r_new_idx);
                        n_out_last   = 1'b1;
                        n_pend_v     = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_v1        <= n_v1;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_j          <= n_j;
        r_last_j     <= n_last_j;
        r_new_idx    <= n_new_idx;
        r_new        <= n_new;
        r_idx1       <= n_idx1;
        r_pend_idx   <= n_pend_idx;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_last   <= n_out_last;
    end

    assign o_pair.valid        = r_out_valid;
    assign o_pair.first_index  = r_out_first;
    assign o_pair.second_index = r_out_second;
    assign o_pair.last_of_run  = r_out_last;

endmodule
